/* rtl/core/sclp_pkg.sv */
`default_nettype none

package sclp_pkg;

  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] PLUS_BYTE  = 8'd43;
  localparam logic [7:0] MINUS_BYTE = 8'd45;
  localparam logic [7:0] ZERO_BYTE  = 8'd48;
  localparam logic [7:0] NINE_BYTE  = 8'd57;
  localparam logic [7:0] TAB_BYTE   = 8'd9;
  localparam logic [7:0] FF_BYTE    = 8'd12;

  localparam int unsigned MAX_ARG_CHARS_DEFAULT = 15;

  localparam int unsigned ValueW = 32;
  localparam logic [ValueW-1:0] MagLimit = 32'h8000_0000;
  localparam logic [ValueW-1:0] PosMax   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_CMD    = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    STG_SKIP   = 2'd0,
    STG_DIGITS = 2'd1,
    STG_DONE   = 2'd2
  } stage_e;

  typedef struct packed {
    logic [ValueW-1:0] accum;
    stage_e            stage;
    logic              negative;
  } arg_conv_t;

  localparam arg_conv_t ArgClear = '{accum: '0, stage: STG_SKIP, negative: 1'b0};

  // atoi-style step on one byte; magnitude saturates at 2^31
  function automatic arg_conv_t conv_byte(arg_conv_t a, logic [7:0] b);
    arg_conv_t         r;
    logic              digit;
    logic              take;
    logic [ValueW+2:0] v;
    r     = a;
    digit = (b >= ZERO_BYTE) && (b <= NINE_BYTE);
    take  = 1'b0;
    case (a.stage)
      STG_SKIP: begin
        if ((b >= TAB_BYTE) && (b <= FF_BYTE)) begin
          r = a;
        end else if ((b == PLUS_BYTE) || (b == MINUS_BYTE)) begin
          r.negative = (b == MINUS_BYTE);
          r.stage    = STG_DIGITS;
        end else if (digit) begin
          r.stage = STG_DIGITS;
          take    = 1'b1;
        end else begin
          r.stage = STG_DONE;
        end
      end
      STG_DIGITS: begin
        if (digit) begin
          take = 1'b1;
        end else begin
          r.stage = STG_DONE;
        end
      end
      default: r = a;
    endcase
    v = ({3'b000, a.accum} << 3) + ({3'b000, a.accum} << 1)
        + {{(ValueW-1){1'b0}}, b[3:0]};
    if (take) begin
      r.accum = (v > {3'b000, MagLimit}) ? MagLimit : v[ValueW-1:0];
    end
    return r;
  endfunction

  function automatic logic [ValueW-1:0] conv_value(arg_conv_t a);
    logic [ValueW-1:0] m;
    m = a.accum;
    if (a.negative) begin
      m = '0 - a.accum;
    end else if (a.accum > PosMax) begin
      m = PosMax;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/serial_command_line_parser_core.sv */
`default_nettype none

// Channel   Dir  Bits  Fields (low bit first)
// s_axis    in      8  data_byte[7:0]
// m_axis    out    72  command_char[7:0], first_value[39:8], second_value[71:40]
//
// One byte a cycle while no carriage return waits on a stalled output: input
// register, one step of the parser (shift-add by ten, compare with 2^31), result
// register. m_axis_tvalid rises as the carriage return leaves the input register.
// A stalled output holds only carriage returns back; other bytes keep flowing.
// rst_ni clears the parser state and both valid flags at once.
module serial_command_line_parser_core #(
  parameter int unsigned MAX_ARG_CHARS = sclp_pkg::MAX_ARG_CHARS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata    // command_char, first_value, second_value
);
  import sclp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ARG_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ARG_CHARS);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  logic [71:0]       out_data_q, out_data_d;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [7:0]        cmd_q, cmd_d;
  arg_conv_t         first_q, first_d;
  arg_conv_t         second_q, second_d;

  logic              is_cr;
  logic              advance;
  logic              s_take;

  assign is_cr         = (in_byte_q == CR_BYTE);
  assign advance       = in_valid_q && (!is_cr || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    in_valid_d  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    phase_d     = phase_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    first_d     = first_q;
    second_d    = second_q;
    if (advance) begin
      if (is_cr) begin
        out_valid_d = 1'b1;
        out_data_d  = {conv_value(second_q), conv_value(first_q), cmd_q};
        phase_d     = PH_CMD;
        count_d     = '0;
        cmd_d       = '0;
        first_d     = ArgClear;
        second_d    = ArgClear;
      end else if (in_byte_q == SPACE_BYTE) begin
        if (phase_q == PH_CMD) begin
          phase_d = PH_FIRST;
        end else if (phase_q == PH_FIRST) begin
          phase_d = PH_SECOND;
          count_d = '0;
        end
      end else if (phase_q == PH_CMD) begin
        cmd_d = in_byte_q;
      end else if (count_q < CntMax) begin
        count_d = count_q + 1'b1;
        if (phase_q == PH_FIRST) begin
          first_d = conv_byte(first_q, in_byte_q);
        end else begin
          second_d = conv_byte(second_q, in_byte_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_CMD;
      count_q     <= '0;
      cmd_q       <= '0;
      first_q     <= ArgClear;
      second_q    <= ArgClear;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      cmd_q       <= cmd_d;
      first_q     <= first_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata;
    end
    out_data_q <= out_data_d;
  end

  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_cr) |=> (phase_q == PH_CMD && count_q == '0 && out_valid_q))
    else $error("line end did not clear parser state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("argument byte count past limit");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_q.accum <= MagLimit) && (second_q.accum <= MagLimit))
    else $error("argument magnitude not saturated");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && is_cr))
    else $error("result raised without a line end");

  a_cmd_field_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CMD) |-> (first_q == ArgClear && second_q == ArgClear))
    else $error("argument touched while in command field");

endmodule

`default_nettype wire
